/* hdl/aes128_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-128 package
// Round tables, field arithmetic and round functions for the block cipher.
// ----------------------------------------------------------------------------
package aes128_pkg;

  localparam int NumRounds = 10;
  localparam int CfgAddrW  = 5;

  localparam logic [1:0] RegKeyHigh  = 2'd0;
  localparam logic [1:0] RegKeyLow   = 2'd1;
  localparam logic [1:0] RegDirection = 2'd2;

  typedef logic [127:0] blk_t;
  typedef logic [7:0]   byte_t;

  localparam byte_t SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam byte_t INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  // Multiply by x in GF(2^8) modulo the AES polynomial.
  function automatic byte_t xt(input byte_t a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // SubBytes, ShiftRows and, except in the last round, MixColumns.
  function automatic blk_t enc_round(input blk_t s, input logic mix);
    byte_t t [16];
    byte_t a0, a1, a2, a3;
    blk_t  o;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[r+4*c] = SBOX[s[127-8*(r+4*((c+r)&3)) -: 8]];
      end
    end
    if (mix) begin
      for (int c = 0; c < 4; c++) begin
        a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
        t[4*c]   = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
        t[4*c+1] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
        t[4*c+2] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
        t[4*c+3] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
      end
    end
    for (int i = 0; i < 16; i++) begin
      o[127-8*i -: 8] = t[i];
    end
    return o;
  endfunction

  function automatic blk_t inv_shift_sub(input blk_t s);
    blk_t o;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        o[127-8*(r+4*c) -: 8] = INV_SBOX[s[127-8*(r+4*((c-r+4)&3)) -: 8]];
      end
    end
    return o;
  endfunction

  function automatic byte_t inv_mul(input byte_t a, input logic [3:0] k);
    byte_t x2, x4, x8;
    x2 = xt(a);
    x4 = xt(x2);
    x8 = xt(x4);
    case (k)
      4'd9:    return x8 ^ a;
      4'd11:   return x8 ^ x2 ^ a;
      4'd13:   return x8 ^ x4 ^ a;
      default: return x8 ^ x4 ^ x2;
    endcase
  endfunction

  function automatic blk_t inv_mix(input blk_t s);
    byte_t a0, a1, a2, a3;
    blk_t  o;
    for (int c = 0; c < 4; c++) begin
      a0 = s[127-8*(4*c)   -: 8];
      a1 = s[127-8*(4*c+1) -: 8];
      a2 = s[127-8*(4*c+2) -: 8];
      a3 = s[127-8*(4*c+3) -: 8];
      o[127-8*(4*c)   -: 8] = inv_mul(a0, 4'd14) ^ inv_mul(a1, 4'd11) ^
                              inv_mul(a2, 4'd13) ^ inv_mul(a3, 4'd9);
      o[127-8*(4*c+1) -: 8] = inv_mul(a0, 4'd9) ^ inv_mul(a1, 4'd14) ^
                              inv_mul(a2, 4'd11) ^ inv_mul(a3, 4'd13);
      o[127-8*(4*c+2) -: 8] = inv_mul(a0, 4'd13) ^ inv_mul(a1, 4'd9) ^
                              inv_mul(a2, 4'd14) ^ inv_mul(a3, 4'd11);
      o[127-8*(4*c+3) -: 8] = inv_mul(a0, 4'd11) ^ inv_mul(a1, 4'd13) ^
                              inv_mul(a2, 4'd9) ^ inv_mul(a3, 4'd14);
    end
    return o;
  endfunction

  // One step of the key schedule: the next round key from the current one.
  function automatic blk_t key_step(input blk_t k, input byte_t rcon);
    logic [31:0] rot, t, w0, w1, w2, w3;
    rot = {k[23:0], k[31:24]};
    t   = {SBOX[rot[31:24]] ^ rcon, SBOX[rot[23:16]], SBOX[rot[15:8]], SBOX[rot[7:0]]};
    w0  = k[127:96] ^ t;
    w1  = k[95:64] ^ w0;
    w2  = k[63:32] ^ w1;
    w3  = k[31:0] ^ w2;
    return {w0, w1, w2, w3};
  endfunction

endpackage

/* hdl/aes128_block_cipher.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-128 block cipher
// Iterative ECB encryption and decryption with a stored round-key schedule.
// ----------------------------------------------------------------------------
// Usage. Load the key through key_high and key_low and pick the direction
// over the APB-style port while no block is in flight. Every key write
// restarts the key schedule, which holds in_stall high while it runs.
// Each input beat carries one 128-bit block; each output beat returns one
// block, in order.
// Operation: a block gets the initial key addition on its input beat, then
// the ten rounds through the single shared round unit, and then the load of
// the output register. A new block is taken as soon as the round unit is
// free, so the unit works on one block at a time and takes no new block
// until the last one has been loaded into the output register.
// A finished block waits in the output register while out_stall is high,
// and the next block may already be accepted and worked on meanwhile; it
// then waits at its last round until the output register empties.
// Reset clears the key to zero, selects encryption, drops out_valid and
// runs the key schedule for the zero key before the first block is taken.
// ----------------------------------------------------------------------------
module aes128_block_cipher
  import aes128_pkg::*;
#(
  parameter int ROUNDS = NumRounds
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [CfgAddrW-1:0] cfg_paddr,
  input  logic [63:0]         cfg_pwdata,
  output logic [63:0]         cfg_prdata,
  output logic                cfg_pready,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [63:0]         in_block_high,
  input  logic [63:0]         in_block_low,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [63:0]         out_result_high,
  output logic [63:0]         out_result_low
);

  localparam int CntW = $clog2(ROUNDS + 1);

  // Configuration registers.
  logic [63:0] key_high_r, key_low_r;
  logic        dir_r;
  logic        cfg_wr;
  logic [1:0]  cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[4:3];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    case (cfg_idx)
      RegKeyHigh:   cfg_prdata = key_high_r;
      RegKeyLow:    cfg_prdata = key_low_r;
      RegDirection: cfg_prdata = {63'd0, dir_r};
      default:      cfg_prdata = 64'd0;
    endcase
  end

  // Key schedule: one round key per cycle, written into the round-key store.
  blk_t            rk_mem_r [ROUNDS+1];
  blk_t            kw_r;
  byte_t           rcon_r;
  logic            exp_busy_r;
  logic [CntW-1:0] exp_cnt_r;
  blk_t            kw_nxt;

  assign kw_nxt = key_step(kw_r, rcon_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r <= 64'd0;
      key_low_r  <= 64'd0;
      dir_r      <= 1'b0;
      exp_busy_r <= 1'b1;
      exp_cnt_r  <= '0;
    end else begin
      if (cfg_wr && (cfg_idx == RegKeyHigh || cfg_idx == RegKeyLow)) begin
        if (cfg_idx == RegKeyHigh) begin
          key_high_r <= cfg_pwdata;
        end else begin
          key_low_r <= cfg_pwdata;
        end
        exp_busy_r <= 1'b1;
        exp_cnt_r  <= '0;
      end else if (exp_busy_r) begin
        exp_cnt_r <= exp_cnt_r + CntW'(1);
        if (exp_cnt_r == CntW'(ROUNDS)) begin
          exp_busy_r <= 1'b0;
        end
      end
      if (cfg_wr && cfg_idx == RegDirection) begin
        dir_r <= cfg_pwdata[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (exp_busy_r) begin
      if (exp_cnt_r == '0) begin
        kw_r        <= {key_high_r, key_low_r};
        rk_mem_r[0] <= {key_high_r, key_low_r};
        rcon_r      <= 8'h01;
      end else begin
        kw_r                <= kw_nxt;
        rk_mem_r[exp_cnt_r] <= kw_nxt;
        rcon_r              <= xt(rcon_r);
      end
    end
  end

  // Round datapath.
  blk_t            st_r, st_nxt;
  logic            run_r;
  logic [CntW-1:0] rnd_r;
  logic [CntW-1:0] step;
  logic [CntW-1:0] rk_idx;
  logic            in_acc, last_rnd, out_load;
  blk_t            rk_sel, dec_tmp;

  assign in_stall = run_r || exp_busy_r;
  assign in_acc   = in_valid && !in_stall;
  assign last_rnd = (rnd_r == CntW'(ROUNDS));
  assign out_load = run_r && last_rnd && (!out_valid || !out_stall);
  assign step     = rnd_r + CntW'(1);

  always_comb begin
    if (!run_r) begin
      rk_idx = dir_r ? CntW'(ROUNDS) : '0;
    end else begin
      rk_idx = dir_r ? CntW'(ROUNDS) - step : step;
    end
  end

  assign rk_sel = rk_mem_r[rk_idx];

  always_comb begin
    dec_tmp = inv_shift_sub(st_r) ^ rk_sel;
    if (!dir_r) begin
      st_nxt = enc_round(st_r, step != CntW'(ROUNDS)) ^ rk_sel;
    end else if (rk_idx != '0) begin
      st_nxt = inv_mix(dec_tmp);
    end else begin
      st_nxt = dec_tmp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      rnd_r <= '0;
    end else if (in_acc) begin
      run_r <= 1'b1;
      rnd_r <= '0;
    end else if (run_r && !last_rnd) begin
      rnd_r <= step;
    end else if (out_load) begin
      run_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      st_r <= {in_block_high, in_block_low} ^ rk_sel;
    end else if (run_r && !last_rnd) begin
      st_r <= st_nxt;
    end
  end

  // Output register.
  logic out_valid_r;
  blk_t out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r <= st_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_high = out_r[127:64];
  assign out_result_low  = out_r[63:0];

  // Checks.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(run_r && exp_busy_r)) else $error("key schedule overlaps a block");

  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> run_r && rnd_r == '0) else $error("block did not start");

  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    run_r && !last_rnd |=> run_r && rnd_r == $past(rnd_r) + CntW'(1))
    else $error("round counter did not advance");

endmodule
